// File: hdl/assert_macros.svh
// Assertion helpers shared by the checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define TMT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define TMT_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/tmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmt_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int MAP_WIDTH_DEF  = 32;
    localparam int Q_DEPTH_DEF    = 2;

    localparam int MASK_W    = 64;
    localparam int MAP_IN_W  = 32;
    localparam int MAP_OUT_W = 32;
    localparam int GROUP_W   = 8;

    typedef enum logic [0:0] {
        FUNC_DEPOSIT = 1'b0,
        FUNC_EXTRACT = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_AVAIL = 3'd1,
        ST_USED  = 3'd2,
        ST_COUNT = 3'd3,
        ST_WIDE  = 3'd4
    } t_status;

    typedef struct packed {
        t_func               func;
        logic [MAP_IN_W-1:0] slot_map_in;
        logic [MASK_W-1:0]   rx_avail_mask;
        logic [MASK_W-1:0]   tx_avail_mask;
        logic [MASK_W-1:0]   rx_used_mask;
        logic [MASK_W-1:0]   tx_used_mask;
    } t_req;

    typedef struct packed {
        logic [MASK_W-1:0]    ts_mask_out;
        logic [MAP_OUT_W-1:0] slot_map_out;
        t_status              status;
    } t_res;

    // Classified request handed from front to back.
    typedef struct packed {
        t_func               func;
        t_status             status;
        logic [MAP_IN_W-1:0] slot_map_in;
        logic [MASK_W-1:0]   avail;
        logic [MASK_W-1:0]   used;
    } t_job;

endpackage

`default_nettype wire

// File: hdl/timeslot_mask_translate_unit.sv
// Channel  | Direction | Handshake          | Payload
// request  | in        | i_valid / o_stall  | i_req (tmt_pkg::t_req)
// result   | out       | o_valid / i_stall  | o_res (tmt_pkg::t_res)
//
// One request per cycle sustained while i_stall is low; a taken request passes
// through the queue (written at the accepting edge), then group ranks, full
// ranks, scatter/gather into o_res.
// Reset clears the queue and all stage valids; payload registers are not reset.
// i_stall freezes the three back stages while a result is held; the 2-entry
// queue takes requests until full, then o_stall (the queue full flag) rises.
`timescale 1ns / 1ps
`default_nettype none

module timeslot_mask_translate_unit #(
    parameter int SLOT_COUNT = tmt_pkg::SLOT_COUNT_DEF,
    parameter int MAP_WIDTH  = tmt_pkg::MAP_WIDTH_DEF,
    parameter int Q_DEPTH    = tmt_pkg::Q_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  tmt_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output tmt_pkg::t_res o_res
);

    tmt_pkg::t_job front_job;
    tmt_pkg::t_job q_job;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic          q_push;

    assign q_push  = i_valid && !q_full;
    assign o_stall = q_full;

    tmt_front #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_front (
        .i_req(i_req),
        .o_job(front_job)
    );

    tmt_queue #(
        .DEPTH(Q_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (front_job),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_data (q_job)
    );

    tmt_back #(
        .SLOT_COUNT(SLOT_COUNT),
        .MAP_WIDTH (MAP_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(!q_empty),
        .i_job      (q_job),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire

// File: hdl/tmt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tmt_front #(
    parameter int SLOT_COUNT = tmt_pkg::SLOT_COUNT_DEF
) (
    input  tmt_pkg::t_req i_req,
    output tmt_pkg::t_job o_job
);

    localparam logic [tmt_pkg::MASK_W-1:0] SlotMask =
        {tmt_pkg::MASK_W{1'b1}} >> (tmt_pkg::MASK_W - SLOT_COUNT);

    logic [tmt_pkg::MASK_W-1:0] avail;
    logic                       used_lost;

    assign avail     = i_req.rx_avail_mask & SlotMask;
    // used slots that are not available (or past the slot range) never get gathered
    assign used_lost = |(i_req.rx_used_mask & ~avail);

    always_comb begin
        o_job.func        = i_req.func;
        o_job.slot_map_in = i_req.slot_map_in;
        o_job.avail       = avail;
        o_job.used        = i_req.rx_used_mask;
        if (i_req.rx_avail_mask != i_req.tx_avail_mask) begin
            o_job.status = tmt_pkg::ST_AVAIL;
        end else if (i_req.func == tmt_pkg::FUNC_EXTRACT &&
                     i_req.rx_used_mask != i_req.tx_used_mask) begin
            o_job.status = tmt_pkg::ST_USED;
        end else if (i_req.func == tmt_pkg::FUNC_EXTRACT && used_lost) begin
            o_job.status = tmt_pkg::ST_COUNT;
        end else begin
            o_job.status = tmt_pkg::ST_OK;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tmt_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tmt_queue #(
    parameter int DEPTH = tmt_pkg::Q_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tmt_pkg::t_job i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output tmt_pkg::t_job o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tmt_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tmt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tmt_back #(
    parameter int SLOT_COUNT = tmt_pkg::SLOT_COUNT_DEF,
    parameter int MAP_WIDTH  = tmt_pkg::MAP_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  tmt_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output tmt_pkg::t_res o_res
);

    localparam int GW   = tmt_pkg::GROUP_W;
    localparam int NG   = (SLOT_COUNT + GW - 1) / GW;
    localparam int PW   = NG * GW;
    localparam int LW   = $clog2(GW);
    localparam int CNTW = $clog2(GW + 1);
    localparam int RW   = $clog2(SLOT_COUNT + 1);
    localparam int IW   = $clog2(SLOT_COUNT);

    logic en;

    // stage A: rank within each group of GW slots
    logic          r_a_valid;
    tmt_pkg::t_job r_a_job;
    logic [LW-1:0]   r_lp [PW], n_lp [PW];
    logic [CNTW-1:0] r_gc [NG], n_gc [NG];

    // stage B: full rank of each slot among the available ones
    logic          r_b_valid;
    tmt_pkg::t_job r_b_job;
    logic [IW-1:0] r_rank [SLOT_COUNT], n_rank [SLOT_COUNT];
    logic [RW-1:0] r_total, n_total;

    logic          r_out_valid;
    tmt_pkg::t_res r_res, n_res;

    // whole back end freezes while a finished result is held
    assign en      = !(r_out_valid && i_stall);
    assign o_pop   = i_job_valid && en;
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    always_comb begin
        logic [PW-1:0]   pad_avail;
        logic [CNTW-1:0] acc;
        pad_avail = PW'(i_job.avail[SLOT_COUNT-1:0]);
        for (int g = 0; g < NG; g++) begin
            acc = '0;
            for (int j = 0; j < GW; j++) begin
                n_lp[g*GW+j] = acc[LW-1:0];
                acc = acc + CNTW'(pad_avail[g*GW+j]);
            end
            n_gc[g] = acc;
        end
    end

    always_comb begin
        logic [RW-1:0] base [NG];
        logic [RW-1:0] bacc;
        bacc = '0;
        for (int g = 0; g < NG; g++) begin
            base[g] = bacc;
            bacc = bacc + RW'(r_gc[g]);
        end
        n_total = bacc;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            n_rank[i] = IW'(base[i/GW] + RW'(r_lp[i]));
        end
    end

    always_comb begin
        logic [tmt_pkg::MASK_W-1:0] map_ext;
        logic [SLOT_COUNT-1:0]      avail;
        logic [SLOT_COUNT-1:0]      sel;
        logic [SLOT_COUNT-1:0]      dep_src;
        logic [SLOT_COUNT-1:0]      dep_mask;
        logic [SLOT_COUNT-1:0]      ext_map;
        logic                       dep_lost;
        logic                       ext_wide;

        map_ext = tmt_pkg::MASK_W'(r_b_job.slot_map_in);
        avail   = r_b_job.avail[SLOT_COUNT-1:0];
        sel     = avail & r_b_job.used[SLOT_COUNT-1:0];

        for (int k = 0; k < SLOT_COUNT; k++) begin
            dep_src[k] = (k < MAP_WIDTH) ? map_ext[k] : 1'b0;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            dep_mask[i] = avail[i] & dep_src[r_rank[i]];
        end
        // map bits past the width limit or past the available slots get dropped
        dep_lost = 1'b0;
        for (int k = 0; k < tmt_pkg::MAP_IN_W; k++) begin
            if (r_b_job.slot_map_in[k] && (k >= MAP_WIDTH || 32'(k) >= 32'(r_total))) begin
                dep_lost = 1'b1;
            end
        end

        for (int k = 0; k < SLOT_COUNT; k++) begin
            ext_map[k] = 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (sel[i] && r_rank[i] == IW'(k)) begin
                    ext_map[k] = 1'b1;
                end
            end
        end
        ext_wide = 1'b0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            if (k >= MAP_WIDTH && ext_map[k]) begin
                ext_wide = 1'b1;
            end
        end

        n_res.ts_mask_out  = '0;
        n_res.slot_map_out = '0;
        n_res.status       = r_b_job.status;
        if (r_b_job.status == tmt_pkg::ST_OK) begin
            if (r_b_job.func == tmt_pkg::FUNC_DEPOSIT) begin
                if (dep_lost) begin
                    n_res.status = tmt_pkg::ST_COUNT;
                end else begin
                    n_res.ts_mask_out = tmt_pkg::MASK_W'(dep_mask);
                end
            end else begin
                if (ext_wide) begin
                    n_res.status = tmt_pkg::ST_WIDE;
                end else begin
                    map_ext = tmt_pkg::MASK_W'(ext_map);
                    n_res.slot_map_out = map_ext[tmt_pkg::MAP_OUT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= i_job_valid;
            r_b_valid   <= r_a_valid;
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_job <= i_job;
            r_lp    <= n_lp;
            r_gc    <= n_gc;
            r_b_job <= r_a_job;
            r_rank  <= n_rank;
            r_total <= n_total;
            r_res   <= n_res;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tmt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tmt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_stall,
    input tmt_pkg::t_res i_res
);

    `TMT_ASSERT(a_out_hold, i_clk, i_rst_n,
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_res),
        "stalled result changed")
    `TMT_ASSERT(a_err_zero, i_clk, i_rst_n,
        i_out_valid && i_res.status != tmt_pkg::ST_OK |->
            i_res.ts_mask_out == '0 && i_res.slot_map_out == '0,
        "error result carries data")
    `TMT_ASSERT(a_one_side, i_clk, i_rst_n,
        i_out_valid |-> i_res.ts_mask_out == '0 || i_res.slot_map_out == '0,
        "both mask and map nonzero")
    `TMT_ASSERT_NR(a_rst_clear, i_clk, !i_rst_n |=> !i_out_valid,
        "result valid right after reset")

endmodule

bind timeslot_mask_translate_unit tmt_checker u_tmt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_valid),
    .i_out_stall(i_stall),
    .i_res      (o_res)
);

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tmt_pkg::*;

    localparam int SLOT_N = SLOT_COUNT_DEF;
    localparam int MAP_N  = MAP_WIDTH_DEF;
    localparam logic [MASK_W-1:0] ALL1 = {MASK_W{1'b1}};
    localparam logic [MASK_W-1:0] TOP1 = {1'b1, {(MASK_W-1){1'b0}}};
    localparam int RAND_PER_PHASE = 184;
    localparam int SETTLE_CYCLES  = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_req i_req   = '0;
    logic o_stall;
    logic o_valid;
    t_res o_res;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;

    t_res pending_results[$];

    // Directed table: request, whether the result is typed in, typed result.
    t_req dir_req[$];
    bit   dir_typed[$];
    t_res dir_res[$];

    timeslot_mask_translate_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_res predict_translation(t_req r);
        t_res               res;
        logic [MASK_W-1:0]  mask;
        logic [MASK_W-1:0]  gathered;
        t_status            st;
        int                 k;
        mask     = '0;
        gathered = '0;
        st       = ST_OK;
        k        = 0;
        if (r.rx_avail_mask != r.tx_avail_mask) begin
            st = ST_AVAIL;
        end else if (r.func == FUNC_DEPOSIT) begin
            for (int i = 0; i < SLOT_N; i++) begin
                if (r.rx_avail_mask[i]) begin
                    if (k < MAP_N && k < MAP_IN_W && r.slot_map_in[k])
                        mask[i] = 1'b1;
                    k++;
                end
            end
            if ($countones(mask) != $countones(r.slot_map_in))
                st = ST_COUNT;
        end else if (r.rx_used_mask != r.tx_used_mask) begin
            st = ST_USED;
        end else begin
            for (int i = 0; i < SLOT_N; i++) begin
                if (r.rx_avail_mask[i]) begin
                    if (r.rx_used_mask[i])
                        gathered[k] = 1'b1;
                    k++;
                end
            end
            if ($countones(r.rx_used_mask) != $countones(gathered))
                st = ST_COUNT;
            else if (MAP_N < MASK_W && (gathered >> MAP_N) != '0)
                st = ST_WIDE;
        end
        if (st != ST_OK) begin
            mask     = '0;
            gathered = '0;
        end
        res.ts_mask_out  = mask;
        res.slot_map_out = gathered[MAP_OUT_W-1:0];
        res.status       = st;
        return res;
    endfunction

    function automatic t_req mk_req(t_func f, logic [MAP_IN_W-1:0] map,
                                    logic [MASK_W-1:0] rxa, logic [MASK_W-1:0] txa,
                                    logic [MASK_W-1:0] rxu, logic [MASK_W-1:0] txu);
        t_req r;
        r.func          = f;
        r.slot_map_in   = map;
        r.rx_avail_mask = rxa;
        r.tx_avail_mask = txa;
        r.rx_used_mask  = rxu;
        r.tx_used_mask  = txu;
        return r;
    endfunction

    function automatic t_res mk_res(logic [MASK_W-1:0] mask, logic [MAP_OUT_W-1:0] map,
                                    t_status st);
        t_res res;
        res.ts_mask_out  = mask;
        res.slot_map_out = map;
        res.status       = st;
        return res;
    endfunction

    task automatic add_row(t_req r, bit typed, t_res res);
        dir_req.push_back(r);
        dir_typed.push_back(typed);
        dir_res.push_back(res);
    endtask

    function automatic logic [MASK_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [MASK_W-1:0] rand_avail();
        logic [MASK_W-1:0] m;
        case ($urandom_range(6))
            0: m = rand64();
            1: m = ALL1;
            2: m = rand64() & rand64() & rand64();
            3: m = rand64() | rand64();
            4: m = ALL1 << $urandom_range(63);
            5: m = ALL1 >> $urandom_range(63);
            default: m = rand64() & rand64();
        endcase
        return m;
    endfunction

    // Mostly consistent requests so the translate paths are exercised;
    // the tail flips a bit in one of the transmit masks.
    function automatic t_req make_random_req();
        t_req              r;
        logic [MASK_W-1:0] av;
        logic [MASK_W-1:0] u;
        int                kind;
        int                lim;
        int                idx;
        kind            = $urandom_range(99);
        av              = rand_avail();
        r.func          = t_func'($urandom_range(1));
        r.slot_map_in   = $urandom;
        r.rx_avail_mask = av;
        r.tx_avail_mask = av;
        if (r.func == FUNC_DEPOSIT) begin
            lim = $countones(av);
            if (lim > MAP_N)
                lim = MAP_N;
            if (kind < 60 && lim < MAP_IN_W)
                r.slot_map_in = r.slot_map_in & ((32'h1 << lim) - 32'h1);
            r.rx_used_mask = rand64();
            r.tx_used_mask = rand64();
        end else begin
            if (kind < 40)
                u = av & rand64() & rand64();
            else if (kind < 60)
                u = av & rand64();
            else if (kind < 75)
                u = (av & rand64()) | (TOP1 >> $urandom_range(63));
            else
                u = rand_avail();
            r.rx_used_mask = u;
            r.tx_used_mask = u;
        end
        if (kind >= 85) begin
            idx = $urandom_range(63);
            if (r.func == FUNC_EXTRACT && $urandom_range(1)) begin
                r.tx_used_mask[idx] = ~r.tx_used_mask[idx];
            end else begin
                r.tx_avail_mask[idx] = ~r.tx_avail_mask[idx];
            end
        end
        return r;
    endfunction

    // Drives one request, holding it until taken, then queues its result.
    task automatic send_request(t_req r, t_res want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(want);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t unexpected result: actual %h", $time, o_res);
                end else begin
                    want = pending_results.pop_front();
                    if (o_res.ts_mask_out !== want.ts_mask_out) begin
                        error_count++;
                        $display("%0t ts_mask_out: expected %h actual %h",
                                 $time, want.ts_mask_out, o_res.ts_mask_out);
                    end
                    if (o_res.slot_map_out !== want.slot_map_out) begin
                        error_count++;
                        $display("%0t slot_map_out: expected %h actual %h",
                                 $time, want.slot_map_out, o_res.slot_map_out);
                    end
                    if (o_res.status !== want.status) begin
                        error_count++;
                        $display("%0t status: expected %0d actual %0d",
                                 $time, want.status, o_res.status);
                    end
                end
            end
        end
    end

    initial begin
        t_req r;
        t_res none;
        none = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(mk_req(FUNC_DEPOSIT, '0, '0, '0, '0, '0), 1, mk_res('0, '0, ST_OK));
        add_row(mk_req(FUNC_DEPOSIT, '1, ALL1, ALL1, '0, '0), 1,
                mk_res(64'h0000_0000_FFFF_FFFF, '0, ST_OK));
        add_row(mk_req(FUNC_DEPOSIT, '1, ALL1 << 32, ALL1 << 32, ALL1, '0), 1,
                mk_res(64'hFFFF_FFFF_0000_0000, '0, ST_OK));
        add_row(mk_req(FUNC_DEPOSIT, 32'h8000_0000, ALL1, ALL1, '0, '0), 1,
                mk_res(64'h0000_0000_8000_0000, '0, ST_OK));
        // Map bit past the last available slot is dropped.
        add_row(mk_req(FUNC_DEPOSIT, 32'h8000_0000, ALL1 >> 33, ALL1 >> 33, '0, '0), 1,
                mk_res('0, '0, ST_COUNT));
        add_row(mk_req(FUNC_DEPOSIT, 32'h1, '0, '0, '0, '0), 1, mk_res('0, '0, ST_COUNT));
        add_row(mk_req(FUNC_DEPOSIT, '1, TOP1, TOP1, '0, '0), 1, mk_res('0, '0, ST_COUNT));
        add_row(mk_req(FUNC_DEPOSIT, 32'h1, TOP1, TOP1, '0, '0), 1, mk_res(TOP1, '0, ST_OK));
        add_row(mk_req(FUNC_DEPOSIT, '1, ALL1, '0, '0, '0), 1, mk_res('0, '0, ST_AVAIL));
        add_row(mk_req(FUNC_DEPOSIT, 32'hDEAD_BEEF, 64'hFFFF_0000_FFFF_0000,
                       64'hFFFF_0000_FFFF_0000, '0, '0), 0, none);
        add_row(mk_req(FUNC_DEPOSIT, 32'h0000_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
                       64'hAAAA_AAAA_AAAA_AAAA, ALL1, 64'h1), 0, none);
        add_row(mk_req(FUNC_EXTRACT, '0, '0, '0, '0, '0), 1, mk_res('0, '0, ST_OK));
        add_row(mk_req(FUNC_EXTRACT, '0, ALL1, ALL1, 64'h1, '0), 1, mk_res('0, '0, ST_USED));
        // Avail mismatch wins over used mismatch.
        add_row(mk_req(FUNC_EXTRACT, '0, ALL1, '0, 64'h1, '0), 1, mk_res('0, '0, ST_AVAIL));
        add_row(mk_req(FUNC_EXTRACT, '1, ALL1, ALL1, ALL1, ALL1), 1, mk_res('0, '0, ST_WIDE));
        add_row(mk_req(FUNC_EXTRACT, '1, ALL1, ALL1, ALL1 >> 32, ALL1 >> 32), 1,
                mk_res('0, 32'hFFFF_FFFF, ST_OK));
        add_row(mk_req(FUNC_EXTRACT, '0, ALL1, ALL1, 64'h1_0000_0000, 64'h1_0000_0000), 1,
                mk_res('0, '0, ST_WIDE));
        add_row(mk_req(FUNC_EXTRACT, '0, '0, '0, 64'h1, 64'h1), 1, mk_res('0, '0, ST_COUNT));
        add_row(mk_req(FUNC_EXTRACT, '0, TOP1, TOP1, TOP1, TOP1), 1,
                mk_res('0, 32'h1, ST_OK));
        add_row(mk_req(FUNC_EXTRACT, '1, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA,
                       64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA), 0, none);
        add_row(mk_req(FUNC_EXTRACT, '0, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA,
                       64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555), 0, none);
        add_row(mk_req(FUNC_EXTRACT, '0, 64'hF0F0_0F0F_FF00_00FF, 64'hF0F0_0F0F_FF00_00FF,
                       64'h9090_0909_8100_0081, 64'h9090_0909_8100_0081), 0, none);

        send_idle_pct = 25;
        recv_idle_pct = 56;
        foreach (dir_req[i])
            send_request(dir_req[i], dir_typed[i] ? dir_res[i] : predict_translation(dir_req[i]));
        // Hold off until the pipe is empty before going random.
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 56 : 0;
            recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 25 : 0;
            repeat (RAND_PER_PHASE) begin
                r = make_random_req();
                send_request(r, predict_translation(r));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/tmt_pkg.sv
hdl/tmt_front.sv
hdl/tmt_queue.sv
hdl/tmt_back.sv
hdl/timeslot_mask_translate_unit.sv
hdl/tmt_checker.sv
dv/testbench.sv
